// ----- design/dmp_pkg.sv -----
// ----------------------------------------------------------------------------
// dmp_pkg
// Shared types and codes for the DNS message parser: token kinds, error codes
// and the token record passed from the parse core to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package dmp_pkg;

  // token kinds
  localparam logic [3:0] KIND_ID        = 4'd0;
  localparam logic [3:0] KIND_FLAGS     = 4'd1;
  localparam logic [3:0] KIND_QDCOUNT   = 4'd2;
  localparam logic [3:0] KIND_ANCOUNT   = 4'd3;
  localparam logic [3:0] KIND_NSCOUNT   = 4'd4;
  localparam logic [3:0] KIND_ARCOUNT   = 4'd5;
  localparam logic [3:0] KIND_LABEL_LEN = 4'd6;
  localparam logic [3:0] KIND_LABEL_BYTE = 4'd7;
  localparam logic [3:0] KIND_NAME_END  = 4'd8;
  localparam logic [3:0] KIND_TYPE      = 4'd9;
  localparam logic [3:0] KIND_CLASS     = 4'd10;
  localparam logic [3:0] KIND_TTL       = 4'd11;
  localparam logic [3:0] KIND_DATA_LEN  = 4'd12;
  localparam logic [3:0] KIND_DATA_BYTE = 4'd13;
  localparam logic [3:0] KIND_END       = 4'd14;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_TRAILING  = 2'd2;

  // packed token width: kind, value, section, record index, error
  localparam int unsigned TOKEN_W = 4 + 32 + 2 + 16 + 2;

  typedef struct packed {
    logic [1:0]  error_code;
    logic [15:0] record_index;
    logic [1:0]  section;
    logic [31:0] field_value;
    logic [3:0]  field_kind;
  } dmp_token_t;

endpackage

`default_nettype wire

// ----- design/dmp_parse_core.sv -----
// ----------------------------------------------------------------------------
// dmp_parse_core
// Parse state of the DNS message parser. Each accepted byte updates the state
// in one step and produces at most one token on the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dmp_parse_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         data_i,
  input  wire logic               last_i,
  output dmp_pkg::dmp_token_t     tok_o,
  output logic                    tok_vld_o
);
  import dmp_pkg::*;

  typedef enum logic [3:0] {
    PH_ID      = 4'd0,
    PH_FLAGS   = 4'd1,
    PH_QDCOUNT = 4'd2,
    PH_ANCOUNT = 4'd3,
    PH_NSCOUNT = 4'd4,
    PH_ARCOUNT = 4'd5,
    PH_NAMELEN = 4'd6,
    PH_LABEL   = 4'd7,
    PH_TYPE    = 4'd8,
    PH_CLASS   = 4'd9,
    PH_TTL     = 4'd10,
    PH_RDLEN   = 4'd11,
    PH_RDATA   = 4'd12,
    PH_DONE    = 4'd13
  } phase_e;

  // first section at or after 'from' with records, 4 when none
  function automatic logic [2:0] first_sec(input logic [3:0] nz, input logic [2:0] from);
    logic [2:0] r;
    r = 3'd4;
    for (int s = 3; s >= 0; s--) begin
      if (nz[s] && (3'(s) >= from)) r = 3'(s);
    end
    return r;
  endfunction

  phase_e      ph_q, ph_d;
  logic [1:0]  bif_q, bif_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] cnt_q [4];
  logic [15:0] cnt_d [4];
  logic [1:0]  sec_q, sec_d;
  logic [15:0] left_q, left_d;
  logic [15:0] rec_q, rec_d;
  logic [7:0]  lab_q, lab_d;
  logic [15:0] dat_q, dat_d;
  logic        trail_q, trail_d;

  logic [31:0] acc_shift;
  logic [3:0]  nz_q, nz_hdr;
  logic [2:0]  ent_sel, fin_sel;
  logic [15:0] left_dec, rec_inc;
  logic [7:0]  lab_dec;
  logic [15:0] dat_dec;

  // finish-record outcome
  phase_e      fin_ph;
  logic [1:0]  fin_sec;
  logic [15:0] fin_left, fin_rec;

  logic        have, trailing;
  dmp_token_t  tok;

  assign acc_shift = {acc_q[23:0], data_i};
  assign nz_q      = {cnt_q[3] != '0, cnt_q[2] != '0, cnt_q[1] != '0, cnt_q[0] != '0};
  assign nz_hdr    = {acc_shift[15:0] != '0, nz_q[2:0]};
  assign ent_sel   = first_sec(nz_hdr, 3'd0);
  assign fin_sel   = first_sec(nz_q, {1'b0, sec_q} + 3'd1);
  assign left_dec  = left_q - 16'd1;
  assign rec_inc   = rec_q + 16'd1;
  assign lab_dec   = lab_q - 8'd1;
  assign dat_dec   = dat_q - 16'd1;

  // end of a record: next record, next non-empty section or done
  always_comb begin
    fin_ph   = PH_NAMELEN;
    fin_sec  = sec_q;
    fin_left = left_dec;
    fin_rec  = rec_inc;
    if (left_dec == '0) begin
      if (!fin_sel[2]) begin
        fin_sec  = fin_sel[1:0];
        fin_left = cnt_q[fin_sel[1:0]];
        fin_rec  = '0;
      end else begin
        fin_ph = PH_DONE;
      end
    end
  end

  // per-byte parse step
  always_comb begin
    ph_d    = ph_q;
    bif_d   = bif_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    sec_d   = sec_q;
    left_d  = left_q;
    rec_d   = rec_q;
    lab_d   = lab_q;
    dat_d   = dat_q;
    trail_d = trail_q;
    have    = 1'b0;
    trailing = 1'b0;
    tok     = '0;

    case (ph_q)
      PH_ID, PH_FLAGS, PH_QDCOUNT, PH_ANCOUNT, PH_NSCOUNT, PH_ARCOUNT: begin
        if (bif_q != 2'd0) begin
          have = 1'b1;
          tok.field_value = acc_shift;
          acc_d = '0;
          bif_d = '0;
          case (ph_q)
            PH_ID: begin
              tok.field_kind = KIND_ID;
              ph_d = PH_FLAGS;
            end
            PH_FLAGS: begin
              tok.field_kind = KIND_FLAGS;
              ph_d = PH_QDCOUNT;
            end
            PH_QDCOUNT: begin
              tok.field_kind = KIND_QDCOUNT;
              cnt_d[0] = acc_shift[15:0];
              ph_d = PH_ANCOUNT;
            end
            PH_ANCOUNT: begin
              tok.field_kind = KIND_ANCOUNT;
              cnt_d[1] = acc_shift[15:0];
              ph_d = PH_NSCOUNT;
            end
            PH_NSCOUNT: begin
              tok.field_kind = KIND_NSCOUNT;
              cnt_d[2] = acc_shift[15:0];
              ph_d = PH_ARCOUNT;
            end
            default: begin
              tok.field_kind = KIND_ARCOUNT;
              cnt_d[3] = acc_shift[15:0];
              if (!ent_sel[2]) begin
                sec_d  = ent_sel[1:0];
                left_d = (ent_sel[1:0] == 2'd3) ? acc_shift[15:0] : cnt_q[ent_sel[1:0]];
                rec_d  = '0;
                ph_d   = PH_NAMELEN;
              end else begin
                ph_d = PH_DONE;
              end
            end
          endcase
        end else begin
          acc_d = acc_shift;
          bif_d = bif_q + 2'd1;
        end
      end
      PH_NAMELEN: begin
        have = 1'b1;
        tok.section = sec_q;
        tok.record_index = rec_q;
        if (data_i != 8'd0) begin
          tok.field_kind  = KIND_LABEL_LEN;
          tok.field_value = {24'd0, data_i};
          lab_d = data_i;
          ph_d  = PH_LABEL;
        end else begin
          tok.field_kind = KIND_NAME_END;
          ph_d = PH_TYPE;
        end
      end
      PH_LABEL: begin
        have = 1'b1;
        tok.section = sec_q;
        tok.record_index = rec_q;
        tok.field_kind  = KIND_LABEL_BYTE;
        tok.field_value = {24'd0, data_i};
        lab_d = lab_dec;
        if (lab_dec == '0) ph_d = PH_NAMELEN;
      end
      PH_TYPE, PH_CLASS, PH_RDLEN: begin
        tok.section = sec_q;
        tok.record_index = rec_q;
        if (bif_q != 2'd0) begin
          have = 1'b1;
          tok.field_value = acc_shift;
          acc_d = '0;
          bif_d = '0;
          case (ph_q)
            PH_TYPE: begin
              tok.field_kind = KIND_TYPE;
              ph_d = PH_CLASS;
            end
            PH_CLASS: begin
              tok.field_kind = KIND_CLASS;
              if (sec_q == 2'd0) begin
                ph_d   = fin_ph;
                sec_d  = fin_sec;
                left_d = fin_left;
                rec_d  = fin_rec;
              end else begin
                ph_d = PH_TTL;
              end
            end
            default: begin
              tok.field_kind  = KIND_DATA_LEN;
              tok.field_value = {16'd0, acc_shift[15:0]};
              dat_d = acc_shift[15:0];
              if (acc_shift[15:0] == '0) begin
                ph_d   = fin_ph;
                sec_d  = fin_sec;
                left_d = fin_left;
                rec_d  = fin_rec;
              end else begin
                ph_d = PH_RDATA;
              end
            end
          endcase
        end else begin
          acc_d = acc_shift;
          bif_d = bif_q + 2'd1;
        end
      end
      PH_TTL: begin
        tok.section = sec_q;
        tok.record_index = rec_q;
        if (bif_q == 2'd3) begin
          have = 1'b1;
          tok.field_kind  = KIND_TTL;
          tok.field_value = acc_shift;
          acc_d = '0;
          bif_d = '0;
          ph_d  = PH_RDLEN;
        end else begin
          acc_d = acc_shift;
          bif_d = bif_q + 2'd1;
        end
      end
      PH_RDATA: begin
        have = 1'b1;
        tok.section = sec_q;
        tok.record_index = rec_q;
        tok.field_kind  = KIND_DATA_BYTE;
        tok.field_value = {24'd0, data_i};
        dat_d = dat_dec;
        if (dat_dec == '0) begin
          ph_d   = fin_ph;
          sec_d  = fin_sec;
          left_d = fin_left;
          rec_d  = fin_rec;
        end
      end
      default: begin
        // parse complete: byte is discarded
        trailing = 1'b1;
        trail_d  = 1'b1;
      end
    endcase

    // last byte of the datagram: always a result, then back to reset state
    if (last_i) begin
      if (trailing || trail_q) tok.error_code = ERR_TRAILING;
      else if (ph_d != PH_DONE) tok.error_code = ERR_TRUNCATED;
      else tok.error_code = ERR_NONE;
      if (!have) begin
        tok.field_kind   = KIND_END;
        tok.field_value  = '0;
        tok.section      = '0;
        tok.record_index = '0;
      end
      ph_d    = PH_ID;
      bif_d   = '0;
      acc_d   = '0;
      for (int i = 0; i < 4; i++) cnt_d[i] = '0;
      sec_d   = '0;
      left_d  = '0;
      rec_d   = '0;
      lab_d   = '0;
      dat_d   = '0;
      trail_d = 1'b0;
    end
  end

  assign tok_o     = tok;
  assign tok_vld_o = have | last_i;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_ID;
      bif_q   <= '0;
      acc_q   <= '0;
      for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
      sec_q   <= '0;
      left_q  <= '0;
      rec_q   <= '0;
      lab_q   <= '0;
      dat_q   <= '0;
      trail_q <= 1'b0;
    end else if (accept_i) begin
      ph_q    <= ph_d;
      bif_q   <= bif_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      sec_q   <= sec_d;
      left_q  <= left_d;
      rec_q   <= rec_d;
      lab_q   <= lab_d;
      dat_q   <= dat_d;
      trail_q <= trail_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/dns_message_parser_top.sv -----
// ----------------------------------------------------------------------------
// dns_message_parser_top
// Byte-stream DNS message parser emitting one token per completed field.
// ----------------------------------------------------------------------------
// Takes one DNS message byte per cycle on the slave stream (tlast marks the
// last byte of the datagram) and emits one token per completed big-endian
// field on the master stream. A byte is parsed in the cycle it is accepted and
// its token appears from the output register on the next cycle, so the block
// sustains one byte per clock; s_axis_tready only drops when the output
// register holds a token the downstream side has not yet taken. Compression
// pointers are not followed, bytes after the last record are dropped and
// flagged on the tlast token, and an early tlast flags a truncated message.
`default_nettype none

module dns_message_parser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // data_byte[7:0]
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tlast,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // field_kind[3:0] field_value[35:4] section[37:36] record_index[53:38]
  // error_code[55:54]
  output logic [55:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready
);
  import dmp_pkg::*;

  logic       accept;
  dmp_token_t tok;
  logic       tok_vld;

  logic       out_vld_q;
  dmp_token_t out_tok_q;
  logic       out_last_q;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  dmp_parse_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .data_i    (s_axis_tdata),
    .last_i    (s_axis_tlast),
    .tok_o     (tok),
    .tok_vld_o (tok_vld)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (accept) begin
      out_vld_q <= tok_vld;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // token payload
  always_ff @(posedge clk_i) begin
    if (accept && tok_vld) begin
      out_tok_q  <= tok;
      out_last_q <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_tok_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DNS message parser.
// ----------------------------------------------------------------------------
// Feeds whole, truncated, padded and garbage datagrams into the byte stream.
// A bit-accurate parse model in the bench predicts every token. The output
// stream is compared token by token against those predictions. Traffic runs
// with and without random gaps and stalls on both streams. One long output
// hold-off lets the parser fill up and stall its input.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dmp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [1:0] SEC_QUESTION = 2'd0;

  // parse phases of the prediction model
  typedef enum logic [3:0] {
    P_ID, P_FLAGS, P_QDCOUNT, P_ANCOUNT, P_NSCOUNT, P_ARCOUNT, P_NAME,
    P_LABEL, P_TYPE, P_CLASS, P_TTL, P_RDLEN, P_RDATA, P_DONE
  } phase_e;

  typedef struct packed {
    logic       msg_end;
    dmp_token_t tok;
  } token_rec_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;

  // traffic shaping
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;

  // bookkeeping
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned tokens_checked = 0;
  int unsigned trunc_cnt = 0;
  int unsigned trail_cnt = 0;

  // prediction model state
  phase_e      parse_ph;
  logic [1:0]  field_byte;
  logic [31:0] field_acc;
  logic [15:0] sect_count [4];
  logic [1:0]  cur_sect;
  logic [15:0] recs_left;
  logic [15:0] cur_rec;
  logic [7:0]  label_left;
  logic [15:0] rdata_left;
  logic        trailing_seen;

  token_rec_t  pending_tokens [$];
  logic [7:0]  frame_q [$];

  dns_message_parser_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // prediction model
  // ---------------------------------------------------------------------------

  function automatic void clear_parse();
    parse_ph      = P_ID;
    field_byte    = 2'd0;
    field_acc     = 32'd0;
    for (int s = 0; s < 4; s++) sect_count[s] = 16'd0;
    cur_sect      = 2'd0;
    recs_left     = 16'd0;
    cur_rec       = 16'd0;
    label_left    = 8'd0;
    rdata_left    = 16'd0;
    trailing_seen = 1'b0;
  endfunction

  // move to the first section from 'from' on that holds records
  function automatic void enter_section(input int from);
    for (int s = from; s < 4; s++) begin
      if (sect_count[s] != 16'd0) begin
        cur_sect  = 2'(s);
        recs_left = sect_count[s];
        cur_rec   = 16'd0;
        parse_ph  = P_NAME;
        return;
      end
    end
    parse_ph = P_DONE;
  endfunction

  function automatic void finish_record();
    recs_left = recs_left - 16'd1;
    cur_rec   = cur_rec + 16'd1;
    if (recs_left == 16'd0) enter_section(int'(cur_sect) + 1);
    else parse_ph = P_NAME;
  endfunction

  // shift one byte into a big-endian field of len bytes, true when complete
  function automatic bit take_byte(input logic [7:0] b, input int len,
                                   output logic [31:0] v);
    v = 32'd0;
    field_acc = {field_acc[23:0], b};
    if (int'(field_byte) + 1 >= len) begin
      v          = field_acc;
      field_acc  = 32'd0;
      field_byte = 2'd0;
      return 1'b1;
    end
    field_byte = field_byte + 2'd1;
    return 1'b0;
  endfunction

  // advance the model by one accepted byte and queue the token it causes
  function automatic void parse_byte(input logic [7:0] b, input logic last);
    bit          have;
    bit          trail;
    logic [3:0]  kind;
    logic [31:0] val;
    logic [1:0]  sect;
    logic [15:0] rec;
    logic [1:0]  err;
    token_rec_t  t;
    have  = 1'b0;
    trail = 1'b0;
    kind  = KIND_ID;
    val   = 32'd0;
    sect  = 2'd0;
    rec   = 16'd0;
    if (parse_ph <= P_ARCOUNT) begin
      // fixed header words
      if (take_byte(b, 2, val)) begin
        have = 1'b1;
        kind = KIND_ID + 4'(parse_ph - P_ID);
        if (parse_ph >= P_QDCOUNT) sect_count[2'(parse_ph - P_QDCOUNT)] = val[15:0];
        if (parse_ph == P_ARCOUNT) enter_section(0);
        else parse_ph = phase_e'(parse_ph + 1);
      end
    end else if (parse_ph < P_DONE) begin
      // record body
      sect = cur_sect;
      rec  = cur_rec;
      case (parse_ph)
        P_NAME: begin
          have = 1'b1;
          if (b != 8'd0) begin
            kind       = KIND_LABEL_LEN;
            val        = 32'(b);
            label_left = b;
            parse_ph   = P_LABEL;
          end else begin
            kind     = KIND_NAME_END;
            parse_ph = P_TYPE;
          end
        end
        P_LABEL: begin
          have       = 1'b1;
          kind       = KIND_LABEL_BYTE;
          val        = 32'(b);
          label_left = label_left - 8'd1;
          if (label_left == 8'd0) parse_ph = P_NAME;
        end
        P_TYPE: begin
          if (take_byte(b, 2, val)) begin
            have     = 1'b1;
            kind     = KIND_TYPE;
            parse_ph = P_CLASS;
          end
        end
        P_CLASS: begin
          if (take_byte(b, 2, val)) begin
            have = 1'b1;
            kind = KIND_CLASS;
            if (cur_sect == SEC_QUESTION) finish_record();
            else parse_ph = P_TTL;
          end
        end
        P_TTL: begin
          if (take_byte(b, 4, val)) begin
            have     = 1'b1;
            kind     = KIND_TTL;
            parse_ph = P_RDLEN;
          end
        end
        P_RDLEN: begin
          if (take_byte(b, 2, val)) begin
            have       = 1'b1;
            kind       = KIND_DATA_LEN;
            val        = {16'd0, val[15:0]};
            rdata_left = val[15:0];
            if (rdata_left == 16'd0) finish_record();
            else parse_ph = P_RDATA;
          end
        end
        default: begin
          have       = 1'b1;
          kind       = KIND_DATA_BYTE;
          val        = 32'(b);
          rdata_left = rdata_left - 16'd1;
          if (rdata_left == 16'd0) finish_record();
        end
      endcase
    end else begin
      // parse already complete, byte is dropped
      trail         = 1'b1;
      trailing_seen = 1'b1;
    end

    if (!last && !have) return;

    err = ERR_NONE;
    if (last) begin
      if (trail || trailing_seen) err = ERR_TRAILING;
      else if (parse_ph < P_DONE) err = ERR_TRUNCATED;
      if (!have) begin
        kind = KIND_END;
        val  = 32'd0;
        sect = 2'd0;
        rec  = 16'd0;
      end
      if (err == ERR_TRAILING) trail_cnt++;
      if (err == ERR_TRUNCATED) trunc_cnt++;
    end
    t.msg_end          = last;
    t.tok.field_kind   = kind;
    t.tok.field_value  = val;
    t.tok.section      = sect;
    t.tok.record_index = rec;
    t.tok.error_code   = err;
    pending_tokens.push_back(t);
    if (last) clear_parse();
  endfunction

  // ---------------------------------------------------------------------------
  // output side: ready generation and token check
  // ---------------------------------------------------------------------------

  // downstream ready, with an optional long hold-off counted here
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // compare each output transfer against the oldest predicted token
  always @(posedge clk_i) begin
    token_rec_t exp_t;
    dmp_token_t act_t;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act_t = dmp_token_t'(m_axis_tdata);
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token, expected none, actual %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
        err_cnt++;
      end else begin
        exp_t = pending_tokens.pop_front();
        tokens_checked++;
        check_field("field_kind", 32'(exp_t.tok.field_kind), 32'(act_t.field_kind));
        check_field("field_value", exp_t.tok.field_value, act_t.field_value);
        check_field("section", 32'(exp_t.tok.section), 32'(act_t.section));
        check_field("record_index", 32'(exp_t.tok.record_index),
                    32'(act_t.record_index));
        check_field("error_code", 32'(exp_t.tok.error_code), 32'(act_t.error_code));
        check_field("message_end", 32'(exp_t.msg_end), 32'(m_axis_tlast));
      end
    end
  end

  // run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // input side: byte transfers and datagram building
  // ---------------------------------------------------------------------------

  // offer one byte, return at the edge where it is taken; valid stays high
  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do begin
        @(posedge clk_i);
      end while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    parse_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
    frame_q.delete();
  endtask

  // drop valid so the bus is quiet
  task automatic idle_bus();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic void put_word(input logic [31:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) frame_q.push_back(v[8*i +: 8]);
  endfunction

  // name: up to two labels, mostly short, rarely a long one or a pointer-looking length
  function automatic void put_name();
    int n_labels;
    int r;
    int len;
    n_labels = $urandom_range(2);
    for (int i = 0; i < n_labels; i++) begin
      r = $urandom_range(99);
      if (r < 2) len = 8'hC0;
      else if (r < 4) len = $urandom_range(6, 255);
      else len = $urandom_range(1, 5);
      frame_q.push_back(8'(len));
      repeat (len) frame_q.push_back(8'($urandom));
    end
    frame_q.push_back(8'h00);
  endfunction

  function automatic void put_record(input int sect);
    int rdlen;
    put_name();
    put_word($urandom, 2);
    put_word($urandom, 2);
    if (sect != 0) begin
      put_word($urandom, 4);
      rdlen = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      put_word(32'(rdlen), 2);
      repeat (rdlen) frame_q.push_back(8'($urandom));
    end
  endfunction

  // well-formed message with small random section counts
  function automatic void build_message();
    int cnt [4];
    for (int s = 0; s < 4; s++) cnt[s] = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 2);
    put_word($urandom, 2);
    put_word($urandom, 2);
    for (int s = 0; s < 4; s++) put_word(32'(cnt[s]), 2);
    for (int s = 0; s < 4; s++) repeat (cnt[s]) put_record(s);
  endfunction

  // mostly whole messages; also cut short, padded, or plain garbage
  task automatic send_random_frame();
    int r;
    int cut;
    r = $urandom_range(99);
    if (r < 12) begin
      repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom));
    end else begin
      build_message();
      if (r < 30) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end else if (r < 45) begin
        repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
      end
    end
    send_frame();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // header only, all counts zero: done right after the header
  task automatic test_empty_message();
    put_word(32'hFFFF, 2);
    put_word(32'h8180, 2);
    repeat (2) put_word(32'h0, 4);
    send_frame();
  endtask

  // datagram of one byte: end marker flagged truncated
  task automatic test_short_frame();
    frame_q.push_back(8'h00);
    send_frame();
  endtask

  // empty message followed by a byte that must be dropped and flagged
  task automatic test_trailing_bytes();
    repeat (3) put_word(32'h0, 4);
    frame_q.push_back(8'hFF);
    send_frame();
  endtask

  // output held off for a long time while input keeps coming
  task automatic test_backpressure();
    int unsigned start;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    idle_bus();
    @(negedge clk_i);
    hold_left = HOLD_CYCLES;
    @(posedge clk_i);
    start = bytes_sent;
    while (bytes_sent - start < 40) send_random_frame();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned n_bytes);
    int unsigned start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) send_random_frame();
  endtask

  // main sequence
  initial begin
    clear_parse();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_message();
    test_short_frame();
    test_trailing_bytes();
    test_backpressure();
    test_random_traffic(0, 0, 300);
    test_random_traffic(86, 0, 300);
    test_random_traffic(0, 86, 300);
    test_random_traffic(36, 36, 300);

    // drain outstanding tokens
    s_axis_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d datagrams, %0d bytes, %0d tokens checked",
             frames_sent, bytes_sent, tokens_checked);
    $display("  %0d ended truncated, %0d ended with dropped trailing bytes",
             trunc_cnt, trail_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
